// ===== rtl/core/bcs_pkg.sv =====
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared types, codes and reset values for the battery charge sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bcs_pkg;

    // Configuration register reset values
    localparam logic [15:0]        MAX_VOLT_RST      = 16'd29000;
    localparam logic [15:0]        RECHARGE_DROP_RST = 16'd1500;
    localparam logic signed [10:0] TEMP_HIGH_RST     = 11'sd430;
    localparam logic signed [10:0] TEMP_RESUME_RST   = 11'sd420;
    localparam logic [14:0]        MIN_CURRENT_RST   = 15'd100;
    localparam logic [5:0]         WATCHDOG_RST      = 6'd50;
    localparam logic [7:0]         SHUTDOWN_HOLD_RST = 8'd15;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_MAX_VOLT      = 3'd0,
        CFG_RECHARGE_DROP = 3'd1,
        CFG_TEMP_HIGH     = 3'd2,
        CFG_TEMP_RESUME   = 3'd3,
        CFG_MIN_CURRENT   = 3'd4,
        CFG_WATCHDOG      = 3'd5,
        CFG_SHUTDOWN_HOLD = 3'd6
    } t_cfg_idx;

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        ST_IDLE       = 9'b000000001,
        ST_CHECK_INIT = 9'b000000010,
        ST_CHECK      = 9'b000000100,
        ST_START      = 9'b000001000,
        ST_CHARGING   = 9'b000010000,
        ST_COOLDOWN   = 9'b000100000,
        ST_FINISHED   = 9'b001000000,
        ST_FAILED     = 9'b010000000,
        ST_SHUTDOWN   = 9'b100000000
    } t_state;

    // Reported state numbers
    localparam logic [3:0] CODE_IDLE       = 4'd0;
    localparam logic [3:0] CODE_CHECK_INIT = 4'd1;
    localparam logic [3:0] CODE_CHECK      = 4'd2;
    localparam logic [3:0] CODE_START      = 4'd3;
    localparam logic [3:0] CODE_CHARGING   = 4'd4;
    localparam logic [3:0] CODE_COOLDOWN   = 4'd5;
    localparam logic [3:0] CODE_FINISHED   = 4'd6;
    localparam logic [3:0] CODE_FAILED     = 4'd7;
    localparam logic [3:0] CODE_SHUTDOWN   = 4'd8;

    // Pin bit positions
    localparam int PIN_EN    = 0;
    localparam int PIN_CHK   = 1;
    localparam int PIN_MOTOR = 2;
    localparam int PIN_PWR   = 3;

    // Message flag bit positions
    localparam int MSG_IN_CHARGER = 0;
    localparam int MSG_FINISHED   = 1;
    localparam int MSG_DISCONN    = 2;
    localparam int MSG_SHUTDOWN   = 3;

    // Delay codes
    localparam logic [1:0] DLY_10MS   = 2'd0;
    localparam logic [1:0] DLY_50MS   = 2'd1;
    localparam logic [1:0] DLY_100MS  = 2'd2;
    localparam logic [1:0] DLY_1000MS = 2'd3;

    // State reset values
    localparam logic [5:0] TICK_RST = 6'd5;
    localparam logic [3:0] PINS_RST = 4'b1000;

    typedef struct packed {
        logic [15:0]        max_volt_mv;
        logic [15:0]        recharge_drop_mv;
        logic signed [10:0] temp_high;
        logic signed [10:0] temp_resume;
        logic [14:0]        min_current_ma;
        logic [5:0]         watchdog_ticks;
        logic [7:0]         shutdown_hold;
    } t_cfg;

    typedef struct packed {
        logic [7:0]         power_key_time;
        logic               power_key;
        logic               chg_present;
        logic               in_charger;
        logic signed [15:0] charge_current_ma;
        logic signed [10:0] battery_temp;
        logic [15:0]        battery_volt_mv;
    } t_item;

    typedef struct packed {
        logic [3:0] state_code;
        logic [1:0] delay_select;
        logic [3:0] msg_flags;
        logic       set_in_charger;
        logic       enable_pulse;
        logic [3:0] pins;
    } t_result;

    function automatic logic [3:0] state_num(input t_state st);
        logic [3:0] code;
        unique case (st)
            ST_IDLE:       code = CODE_IDLE;
            ST_CHECK_INIT: code = CODE_CHECK_INIT;
            ST_CHECK:      code = CODE_CHECK;
            ST_START:      code = CODE_START;
            ST_CHARGING:   code = CODE_CHARGING;
            ST_COOLDOWN:   code = CODE_COOLDOWN;
            ST_FINISHED:   code = CODE_FINISHED;
            ST_FAILED:     code = CODE_FAILED;
            ST_SHUTDOWN:   code = CODE_SHUTDOWN;
            default:       code = CODE_SHUTDOWN;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bcs_cfg.sv =====
// ----------------------------------------------------------------------------
// bcs_cfg
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bcs_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr_en,
    input  wire logic [2:0]    i_cfg_addr,
    input  wire logic [15:0]   i_cfg_wdata,
    output bcs_pkg::t_cfg      o_cfg
);

    bcs_pkg::t_cfg r_cfg;
    bcs_pkg::t_cfg n_cfg;

    // Address decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                bcs_pkg::CFG_MAX_VOLT:      n_cfg.max_volt_mv      = i_cfg_wdata;
                bcs_pkg::CFG_RECHARGE_DROP: n_cfg.recharge_drop_mv = i_cfg_wdata;
                bcs_pkg::CFG_TEMP_HIGH:     n_cfg.temp_high        = i_cfg_wdata[10:0];
                bcs_pkg::CFG_TEMP_RESUME:   n_cfg.temp_resume      = i_cfg_wdata[10:0];
                bcs_pkg::CFG_MIN_CURRENT:   n_cfg.min_current_ma   = i_cfg_wdata[14:0];
                bcs_pkg::CFG_WATCHDOG:      n_cfg.watchdog_ticks   = i_cfg_wdata[5:0];
                bcs_pkg::CFG_SHUTDOWN_HOLD: n_cfg.shutdown_hold    = i_cfg_wdata[7:0];
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_volt_mv      <= bcs_pkg::MAX_VOLT_RST;
            r_cfg.recharge_drop_mv <= bcs_pkg::RECHARGE_DROP_RST;
            r_cfg.temp_high        <= bcs_pkg::TEMP_HIGH_RST;
            r_cfg.temp_resume      <= bcs_pkg::TEMP_RESUME_RST;
            r_cfg.min_current_ma   <= bcs_pkg::MIN_CURRENT_RST;
            r_cfg.watchdog_ticks   <= bcs_pkg::WATCHDOG_RST;
            r_cfg.shutdown_hold    <= bcs_pkg::SHUTDOWN_HOLD_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/core/bcs_fsm.sv =====
// ----------------------------------------------------------------------------
// bcs_fsm
// Charger sequencer: state, watchdog counter, delay and pin registers, and
// the per-tick next-state logic that forms one result.
// ----------------------------------------------------------------------------
`default_nettype none

module bcs_fsm (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire bcs_pkg::t_item   i_item,
    input  wire bcs_pkg::t_cfg    i_cfg,
    output bcs_pkg::t_result      o_result,
    output bcs_pkg::t_state       o_state
);

    bcs_pkg::t_state r_state, n_state;
    logic [5:0]      r_tick, n_tick;
    logic [1:0]      r_delay, n_delay;
    logic [3:0]      r_pins, n_pins;

    logic               pulse;
    logic               setin;
    logic [3:0]         msg;
    logic [5:0]         tick_base;
    logic [5:0]         tick_dec;
    logic               cur_alive;
    logic               volt_over;
    logic signed [16:0] recharge_thr;
    logic               volt_low;

    // Threshold compares
    assign cur_alive    = i_item.charge_current_ma > $signed({2'b00, i_cfg.min_current_ma});
    assign volt_over    = i_item.battery_volt_mv > i_cfg.max_volt_mv;
    assign recharge_thr = $signed({1'b0, i_cfg.max_volt_mv})
                        - $signed({1'b0, i_cfg.recharge_drop_mv});
    assign volt_low     = $signed({1'b0, i_item.battery_volt_mv}) < recharge_thr;

    // Next-state logic for one tick
    always_comb begin
        n_state   = r_state;
        n_tick    = r_tick;
        n_delay   = r_delay;
        n_pins    = r_pins;
        pulse     = 1'b0;
        setin     = 1'b0;
        msg       = 4'd0;
        tick_base = r_tick;
        tick_dec  = r_tick - 6'd1;

        if (r_state == bcs_pkg::ST_SHUTDOWN) begin
            // halted: everything off, delay kept
            n_pins = 4'd0;
        end else begin
            unique case (r_state)
                bcs_pkg::ST_IDLE: begin
                    n_delay = bcs_pkg::DLY_1000MS;
                    n_tick  = i_cfg.watchdog_ticks;
                    n_state = bcs_pkg::ST_CHECK_INIT;
                end
                bcs_pkg::ST_CHECK_INIT: begin
                    n_delay                  = bcs_pkg::DLY_10MS;
                    n_pins[bcs_pkg::PIN_CHK] = 1'b1;
                    n_tick                   = i_cfg.watchdog_ticks;
                    n_state                  = bcs_pkg::ST_CHECK;
                end
                bcs_pkg::ST_CHECK: begin
                    if (i_item.chg_present) begin
                        n_pins[bcs_pkg::PIN_CHK]   = 1'b0;
                        n_pins[bcs_pkg::PIN_MOTOR] = 1'b1;
                        setin                      = 1'b1;
                        n_state                    = bcs_pkg::ST_START;
                        tick_base                  = i_cfg.watchdog_ticks;
                        msg[bcs_pkg::MSG_IN_CHARGER] = 1'b1;
                    end
                    tick_dec = tick_base - 6'd1;
                    n_tick   = tick_dec;
                    if (tick_dec == 6'd0) begin
                        n_pins[bcs_pkg::PIN_CHK]   = 1'b0;
                        n_pins[bcs_pkg::PIN_MOTOR] = 1'b1;
                        n_state                    = bcs_pkg::ST_IDLE;
                    end
                end
                bcs_pkg::ST_START: begin
                    n_pins[bcs_pkg::PIN_EN] = 1'b1;
                    n_delay                 = bcs_pkg::DLY_100MS;
                    n_state                 = bcs_pkg::ST_CHARGING;
                    n_tick                  = i_cfg.watchdog_ticks;
                end
                bcs_pkg::ST_CHARGING: begin
                    if (cur_alive) begin
                        tick_base = i_cfg.watchdog_ticks;
                        if (i_item.battery_temp > i_cfg.temp_high) begin
                            n_state = bcs_pkg::ST_COOLDOWN;
                        end
                        if (!i_item.in_charger) begin
                            setin = 1'b1;
                        end
                    end
                    if (volt_over) begin
                        n_pins[bcs_pkg::PIN_CHK]    = 1'b1;
                        n_state                     = bcs_pkg::ST_FINISHED;
                        msg[bcs_pkg::MSG_FINISHED]  = 1'b1;
                    end
                    tick_dec = tick_base - 6'd1;
                    n_tick   = tick_dec;
                    if (tick_dec == 6'd0) begin
                        n_state                   = bcs_pkg::ST_FAILED;
                        msg[bcs_pkg::MSG_DISCONN] = 1'b1;
                    end
                end
                bcs_pkg::ST_COOLDOWN: begin
                    n_delay                 = bcs_pkg::DLY_1000MS;
                    pulse                   = 1'b1;
                    n_pins[bcs_pkg::PIN_EN] = 1'b0;
                    if (i_item.battery_temp < i_cfg.temp_resume) begin
                        n_state = bcs_pkg::ST_START;
                    end
                end
                bcs_pkg::ST_FINISHED: begin
                    n_delay                 = bcs_pkg::DLY_1000MS;
                    pulse                   = 1'b1;
                    n_pins[bcs_pkg::PIN_EN] = 1'b0;
                    if (!i_item.in_charger) begin
                        n_state = bcs_pkg::ST_IDLE;
                    end
                    if (volt_low) begin
                        n_state = bcs_pkg::ST_START;
                    end
                end
                bcs_pkg::ST_FAILED: begin
                    n_delay = bcs_pkg::DLY_1000MS;
                    n_state = bcs_pkg::ST_CHECK_INIT;
                end
                default: begin
                    n_state = bcs_pkg::ST_SHUTDOWN;
                end
            endcase

            // power key: flag, and shutdown on a long hold
            if (i_item.power_key) begin
                msg[bcs_pkg::MSG_SHUTDOWN] = 1'b1;
                if (i_item.power_key_time > i_cfg.shutdown_hold) begin
                    n_state = bcs_pkg::ST_SHUTDOWN;
                end
            end
        end
    end

    // Sequencer registers, stepped once per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcs_pkg::ST_START;
            r_tick  <= bcs_pkg::TICK_RST;
            r_delay <= bcs_pkg::DLY_50MS;
            r_pins  <= bcs_pkg::PINS_RST;
        end else if (i_step) begin
            r_state <= n_state;
            r_tick  <= n_tick;
            r_delay <= n_delay;
            r_pins  <= n_pins;
        end
    end

    // Result of this tick
    always_comb begin
        o_result.pins           = n_pins;
        o_result.enable_pulse   = pulse;
        o_result.set_in_charger = setin;
        o_result.msg_flags      = msg;
        o_result.delay_select   = n_delay;
        o_result.state_code     = bcs_pkg::state_num(n_state);
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

// ===== rtl/core/battery_charge_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// battery_charge_sequencer_top
// Battery charger sequencer stepped by one input item per task tick.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the s_axis channel is one task tick with the battery
//   measurements and key state. The sequencer steps once per accepted item
//   and returns exactly one result item on m_axis: pin levels, enable pulse,
//   in-charger writeback, message flags, next tick delay and state number.
//   The result is registered and is valid the cycle after acceptance.
//   Throughput is one item per cycle; the next-state logic is a single
//   combinational pass between the sequencer registers and the result
//   register. A new item is accepted while a result waits, as long as the
//   receiver takes that result in the same cycle.
//   When the receiver stalls, the result is held and s_axis_tready drops
//   until it is taken.
//   Reset (i_rst_n low, synchronous) puts the sequencer in start charging,
//   the watchdog counter at five, the delay at 50 ms, only system power on,
//   and all registers at their defaults. Registers must be written through
//   the cfg port while the block is idle; the block does not enforce this.
//   After the shutdown tick the block stays halted with all pins off.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_charge_sequencer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // config write port
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    // input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [15:0] battery_volt_mv, [26:16] battery_temp, [42:27] charge_current_ma,
    // [43] in_charger, [44] chg_present, [45] power_key,
    // [53:46] power_key_time, [55:54] zero
    input  wire logic [55:0] s_axis_tdata,
    // result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] chg_enable, [1] chg_check, [2] motor_power, [3] system_power,
    // [4] enable_pulse, [5] set_in_charger, [9:6] msg_flags,
    // [11:10] delay_select, [15:12] state_code
    output logic [15:0]      m_axis_tdata
);

    bcs_pkg::t_cfg    cfg;
    bcs_pkg::t_item   item;
    bcs_pkg::t_result result;
    bcs_pkg::t_state  state;
    logic             step;

    logic        r_out_valid;
    logic [15:0] r_out_data;

    // Unpack input item
    assign item = bcs_pkg::t_item'(s_axis_tdata[53:0]);

    // Handshake: accept when the result register is free or being drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    bcs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bcs_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (item),
        .i_cfg    (cfg),
        .o_result (result),
        .o_state  (state)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // a tick taken in shutdown reports every pin off
    a_halt_pins_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && state == bcs_pkg::ST_SHUTDOWN) |=> (m_axis_tvalid && m_axis_tdata[3:0] == 4'd0))
        else $error("halted tick drove a pin");

    // an enable pulse always leaves the enable switch open
    a_pulse_en_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[4]) |-> !m_axis_tdata[0])
        else $error("enable pulse with enable switch closed");

    // every accepted item yields a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> m_axis_tvalid)
        else $error("accepted item produced no result");

    // once shut down the sequencer never leaves
    a_shutdown_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == bcs_pkg::ST_SHUTDOWN) |=> (state == bcs_pkg::ST_SHUTDOWN))
        else $error("sequencer left shutdown");
`endif

endmodule

`default_nettype wire
